FILE: hdl/abad_pkg.sv
// Shared constants and control types for the adaptive binary arithmetic decoder.
package abad_pkg;

  localparam int CTX_BITS_DEF    = 8;
  localparam int COUNT_LIMIT_DEF = 268435455;
  localparam int CNT_W           = 28;
  localparam int DEN_W           = 30;
  localparam int PROB_W          = 32;
  localparam int DIV_STEPS       = 32;
  localparam int ST_W            = 4;

  localparam logic REQ_FEED   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef struct packed {
    logic feed;
    logic reject;
    logic start;
    logic mul;
    logic mid;
    logic upd;
    logic dload;
    logic dstep;
    logic fin;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic needed;
    logic out_free;
  } stat_t;

endpackage

FILE: hdl/adaptive_binary_arithmetic_decoder_top.sv
// Top level of the adaptive binary arithmetic decoder.
// One request at a time. A byte feed or a rejected decode goes from acceptance to ST_FIN,
// where its result enters the output register once the output is free; a decoded bit
// passes through multiply, split and count-memory steps and the 32-step serial division
// that forms the next probability. After reset a clearing pass zeroes all 2^CONTEXT_BITS
// entries of the count memory before the first request is taken.
module adaptive_binary_arithmetic_decoder_top #(
  parameter int CONTEXT_BITS = abad_pkg::CTX_BITS_DEF,
  parameter int COUNT_LIMIT  = abad_pkg::COUNT_LIMIT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // byte_in
  input  logic       s_axis_tuser,  // req_type
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // decoded_bit, need_byte, rejected, zero fill
  output logic       m_axis_tuser   // bit_valid
);
  import abad_pkg::*;

  cmd_t                    cmd;
  stat_t                   stat;
  logic [CONTEXT_BITS-1:0] clr_addr;

  abad_ctrl #(.CONTEXT_BITS(CONTEXT_BITS)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready), .in_tuser(s_axis_tuser),
    .stat(stat), .cmd(cmd), .clr_addr(clr_addr)
  );

  abad_dp #(.CONTEXT_BITS(CONTEXT_BITS), .COUNT_LIMIT(COUNT_LIMIT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .clr_addr(clr_addr),
    .byte_in(s_axis_tdata),
    .out_tvalid(m_axis_tvalid), .out_tready(m_axis_tready),
    .out_tdata(m_axis_tdata), .out_tuser(m_axis_tuser)
  );

endmodule

FILE: hdl/abad_ctrl.sv
// Sequencer: clearing pass, request dispatch, decode steps and serial division.
module abad_ctrl #(
  parameter int CONTEXT_BITS = abad_pkg::CTX_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic                    in_tuser,
  input  abad_pkg::stat_t         stat,
  output abad_pkg::cmd_t          cmd,
  output logic [CONTEXT_BITS-1:0] clr_addr
);
  import abad_pkg::*;

  localparam logic [ST_W-1:0] ST_CLR   = 4'd0;
  localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
  localparam logic [ST_W-1:0] ST_MUL   = 4'd2;
  localparam logic [ST_W-1:0] ST_MID   = 4'd3;
  localparam logic [ST_W-1:0] ST_UPD   = 4'd4;
  localparam logic [ST_W-1:0] ST_RD    = 4'd5;
  localparam logic [ST_W-1:0] ST_DLOAD = 4'd6;
  localparam logic [ST_W-1:0] ST_DIV   = 4'd7;
  localparam logic [ST_W-1:0] ST_FIN   = 4'd8;

  logic [ST_W-1:0]         state, state_next;
  logic [4:0]              div_cnt;
  logic [CONTEXT_BITS-1:0] clr_cnt;

  assign clr_addr = clr_cnt;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_tready  = 1'b0;
    unique case (state)
      ST_CLR: begin
        cmd.clr = 1'b1;
        if (clr_cnt == {CONTEXT_BITS{1'b1}}) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == REQ_FEED) begin
            cmd.feed   = 1'b1;
            state_next = ST_FIN;
          end else if (stat.needed) begin
            cmd.reject = 1'b1;
            state_next = ST_FIN;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_MID;
      end
      ST_MID: begin
        cmd.mid    = 1'b1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd    = 1'b1;
        state_next = ST_RD;
      end
      ST_RD: state_next = ST_DLOAD;
      ST_DLOAD: begin
        cmd.dload  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.dstep = 1'b1;
        if (div_cnt == 5'(DIV_STEPS - 1)) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLR;
      div_cnt <= '0;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (cmd.clr) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.dstep) div_cnt <= div_cnt + 1'b1;
      else div_cnt <= '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_tready |-> state == ST_IDLE) else $error("ready outside idle");
  a_start_mul: assert property (@(posedge clk) disable iff (rst)
    (in_tvalid && in_tready && in_tuser == REQ_DECODE && !stat.needed) |=> state == ST_MUL)
    else $error("decode did not start");
  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && stat.out_free) |=> state == ST_IDLE) else $error("result stuck");
`endif

endmodule

FILE: hdl/abad_dp.sv
// Datapath: interval registers, count memory, multiplier, divider, output register.
module abad_dp #(
  parameter int CONTEXT_BITS = abad_pkg::CTX_BITS_DEF,
  parameter int COUNT_LIMIT  = abad_pkg::COUNT_LIMIT_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  abad_pkg::cmd_t          cmd,
  output abad_pkg::stat_t         stat,
  input  logic [CONTEXT_BITS-1:0] clr_addr,
  input  logic [7:0]              byte_in,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,
  output logic                    out_tuser
);
  import abad_pkg::*;

  localparam int DEPTH = 1 << CONTEXT_BITS;

  logic [63:0]             low, high, code, prod, mid;
  logic [31:0]             diff_hi, prob, quo;
  logic [CONTEXT_BITS-1:0] ctx;
  logic [3:0]              preload;
  logic [2*CNT_W-1:0]      mem [DEPTH];
  logic [2*CNT_W-1:0]      rdata;
  logic [DEN_W-1:0]        rem, den;
  logic                    res_bit, res_valid, res_rej;
  logic                    o_bit, o_valid, o_need, o_rej;

  logic                    y, top_eq, needed, over;
  logic [CNT_W-1:0]        c_one, c_zero, n_one, n_zero;
  logic [CNT_W:0]          bumped;
  logic [CONTEXT_BITS:0]   ctx_sh;
  logic [DEN_W:0]          dt;
  logic                    ge;

  assign top_eq = low[63:56] == high[63:56];
  assign needed = (preload != 4'd0) || top_eq;
  assign stat.needed   = needed;
  assign stat.out_free = !out_tvalid || out_tready;

  assign c_one  = rdata[2*CNT_W-1:CNT_W];
  assign c_zero = rdata[CNT_W-1:0];
  assign y      = code <= mid;
  assign bumped = {1'b0, (y ? c_one : c_zero)} + 1'b1;
  assign over   = bumped > (CNT_W+1)'(COUNT_LIMIT);
  assign ctx_sh = {ctx, y};

  always_comb begin
    n_one  = c_one;
    n_zero = c_zero;
    if (y) n_one = bumped[CNT_W-1:0];
    else n_zero = bumped[CNT_W-1:0];
    if (over) begin
      if (y) begin
        n_one  = bumped[CNT_W:1];
        n_zero = c_zero >> 1;
      end else begin
        n_zero = bumped[CNT_W:1];
        n_one  = c_one >> 1;
      end
    end
  end

  assign dt = {rem, 1'b0};
  assign ge = dt >= {1'b0, den};

  always_ff @(posedge clk) begin
    rdata <= mem[ctx];
    if (cmd.clr) mem[clr_addr] <= '0;
    else if (cmd.upd) mem[ctx] <= {n_one, n_zero};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low     <= '0;
      high    <= '1;
      code    <= '0;
      ctx     <= '0;
      prob    <= 32'hFFFF_FFFF;
      preload <= 4'd8;
      out_tvalid <= 1'b0;
    end else begin
      if (cmd.feed) begin
        if (preload != 4'd0) begin
          code    <= {code[55:0], byte_in};
          preload <= preload - 1'b1;
        end else if (top_eq) begin
          low  <= {low[55:0], 8'h00};
          high <= {high[55:0], 8'hFF};
          code <= {code[55:0], byte_in};
        end
      end
      if (cmd.upd) begin
        if (y) high <= mid;
        else low <= mid + 64'd1;
        ctx <= ctx_sh[CONTEXT_BITS-1:0];
      end
      if (cmd.fin) begin
        if (res_valid) prob <= quo;
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) diff_hi <= 32'((high - low) >> 32);
    if (cmd.mul) prod <= 64'(diff_hi) * 64'(prob);
    if (cmd.mid) mid <= low + prod;
    if (cmd.feed || cmd.reject) begin
      res_bit   <= 1'b0;
      res_valid <= 1'b0;
      res_rej   <= cmd.reject;
    end
    if (cmd.upd) begin
      res_bit   <= y;
      res_valid <= 1'b1;
      res_rej   <= 1'b0;
    end
    if (cmd.dload) begin
      rem <= DEN_W'(c_one) + DEN_W'(1);
      den <= DEN_W'(c_zero) + DEN_W'(c_one) + DEN_W'(2);
      quo <= '0;
    end
    if (cmd.dstep) begin
      rem <= ge ? DEN_W'(dt - {1'b0, den}) : dt[DEN_W-1:0];
      quo <= {quo[30:0], ge};
    end
    if (cmd.fin) begin
      o_bit   <= res_bit;
      o_valid <= res_valid;
      o_need  <= needed;
      o_rej   <= res_rej;
    end
  end

  assign out_tdata = {5'd0, o_rej, o_need, o_bit};
  assign out_tuser = o_valid;

`ifndef NO_ASSERTIONS
  a_den_nz: assert property (@(posedge clk) disable iff (rst)
    cmd.dstep |-> den != '0) else $error("zero divisor");
  a_rem_lt: assert property (@(posedge clk) disable iff (rst)
    cmd.dstep |-> rem < den) else $error("remainder out of range");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> out_tvalid) else $error("result not presented");
`endif

endmodule
